// File: rtl/core/rbds_pkg.sv
// Shared types and constants for the RGB 2x2 box downscaler.
package rbds_pkg;

  localparam int ChanW   = 8;
  localparam int SumW    = ChanW + 1;
  localparam int WidthW  = 12;
  localparam int HeightW = 16;
  localparam int OutColW = 10;
  localparam int OutRowW = 15;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0]   red_avg;
    logic [ChanW-1:0]   green_avg;
    logic [ChanW-1:0]   blue_avg;
    logic [OutColW-1:0] out_col;
    logic [OutRowW-1:0] out_row;
    logic               frame_last;
  } result_t;

  // Column-pair sums kept in the line store.
  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } pair_t;

  typedef struct packed {
    pair_t              pair;
    logic [OutColW-1:0] out_col;
    logic [OutRowW-1:0] out_row;
    logic               frame_last;
  } stage_t;

endpackage

// File: rtl/core/rbds_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rbds_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rgb_box_downscale_2x2_unit.sv
// Top level of the RGB 2x2 box-filter downscaler with its line store.
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_stall   pixel_t  (red, green, blue)
//   out       output     out_valid/out_stall result_t (averages, position, frame_last)
//   cfg       input      cfg_valid/cfg_ready cfg_index_i, cfg_data_i
//
// One pixel per clock while in_stall_o is low; after the transaction that completes
// its 2x2 block, a result passes the line store read stage, then the output register.
// Line store RAM: written on even rows, read on odd rows, one access per pixel pair.
// Reset clears counters, held pixel, valids; width 2048, height 2; RAM not cleared.
// in_stall_o rises only when a result waits in the read stage behind a stalled output.
module rgb_box_downscale_2x2_unit
  import rbds_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pixel_t             in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output result_t            out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int ColW      = (MAX_WIDTH > 4096) ? WidthW : $clog2(MAX_WIDTH);
  localparam int AddrW     = (ColW > 1) ? ColW - 1 : 1;
  localparam int LineDepth = 1 << AddrW;
  localparam logic [WidthW:0] MaxEff =
    (WidthW + 1)'((MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH);

  logic [WidthW-1:0]  width_q, width_d;
  logic [HeightW-1:0] height_q, height_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  pixel_t             held_q;
  logic               s1_valid_q, s1_valid_d;
  stage_t             s1_q, s1_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic [WidthW-1:0]  eff_w;
  logic               accept, in_range, odd_col, odd_row, row_in;
  logic               out_free, s1_free;
  logic               line_we, line_re;
  logic [AddrW-1:0]   line_addr;
  pair_t              pair, line_old;
  logic [WidthW:0]    col_inc;
  logic [HeightW:0]   row_inc;
  logic [WidthW-1:0]  oc_ext;
  logic [SumW:0]      sum_r, sum_g, sum_b;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegImageWidth:  width_d  = cfg_data_i[WidthW-1:0];
        RegImageHeight: height_d = cfg_data_i[HeightW-1:0];
        default:        ;
      endcase
    end
  end

  assign eff_w = ({1'b0, width_q} > MaxEff) ? MaxEff[WidthW-1:0] : width_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_range = (WidthW + 1)'(col_q) < {1'b0, eff_w};
  assign odd_col  = col_q[0];
  assign odd_row  = row_q[0];
  assign row_in   = row_q < height_q;

  assign pair.red   = SumW'(held_q.red)   + SumW'(in_data_i.red);
  assign pair.green = SumW'(held_q.green) + SumW'(in_data_i.green);
  assign pair.blue  = SumW'(held_q.blue)  + SumW'(in_data_i.blue);

  // Rows of a block are at least one transaction apart, so a read never meets
  // a write to the same entry still in flight.
  assign line_we   = accept && in_range && odd_col && !odd_row;
  assign line_re   = accept && in_range && odd_col && odd_row && row_in;
  assign line_addr = AddrW'(col_q >> 1);

  rbds_ram #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (LineDepth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_addr),
    .wdata_i (pair),
    .re_i    (line_re),
    .raddr_i (line_addr),
    .rdata_o (line_old)
  );

  assign oc_ext  = WidthW'(col_q >> 1);
  assign col_inc = (WidthW + 1)'(col_q) + (WidthW + 1)'(1);
  assign row_inc = (HeightW + 1)'(row_q) + (HeightW + 1)'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= {1'b0, eff_w}) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, height_q}) ? '0 : row_inc[HeightW-1:0];
      end else begin
        col_d = ColW'(col_inc);
      end
    end
  end

  always_comb begin
    s1_d            = s1_q;
    s1_d.pair       = pair;
    s1_d.out_col    = OutColW'(col_q >> 1);
    s1_d.out_row    = row_q[HeightW-1:1];
    s1_d.frame_last = ((oc_ext + WidthW'(1)) == {1'b0, eff_w[WidthW-1:1]}) &&
                      (({1'b0, row_q[HeightW-1:1]} + HeightW'(1)) ==
                       {1'b0, height_q[HeightW-1:1]});
    if (line_re) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  assign sum_r = (SumW + 1)'(line_old.red)   + (SumW + 1)'(s1_q.pair.red);
  assign sum_g = (SumW + 1)'(line_old.green) + (SumW + 1)'(s1_q.pair.green);
  assign sum_b = (SumW + 1)'(line_old.blue)  + (SumW + 1)'(s1_q.pair.blue);

  always_comb begin
    out_d            = out_q;
    out_d.red_avg    = sum_r[SumW:2];
    out_d.green_avg  = sum_g[SumW:2];
    out_d.blue_avg   = sum_b[SumW:2];
    out_d.out_col    = s1_q.out_col;
    out_d.out_row    = s1_q.out_row;
    out_d.frame_last = s1_q.frame_last;
    out_valid_d      = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidthW'(2048);
      height_q    <= HeightW'(2);
      col_q       <= '0;
      row_q       <= '0;
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept && in_range && !odd_col) begin
        held_q <= in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      s1_q <= s1_d;
    end
    if (out_free && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/rbds_check.sv
// Port-level checker for the 2x2 box downscaler, bound to the top level.
module rbds_check
  import rbds_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input pixel_t             in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input result_t            out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [CfgW-1:0]    cfg_data_i
);

  // held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled, full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // a fresh result traces to an accepted transaction via the read stage and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without source transaction");

  // the config port never blocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind rgb_box_downscale_2x2_unit rbds_check u_rbds_check (.*);

// File: verif/box_avg_check_pkg.sv
// Scoreboard for the RGB 2x2 downscaler: predicts block averages and checks results.
`timescale 1ns / 1ps
package box_avg_check_pkg;
  import rbds_pkg::*;

  localparam int MaxWidth  = 2048;
  localparam int LineDepth = MaxWidth / 2;

  class box_avg_scoreboard;
    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    pair_t              pair_line [LineDepth];
    pixel_t             held_px;
    int unsigned        col_pos;
    int unsigned        row_pos;
    result_t            block_avgs_q [$];
    int                 n_errors;
    int                 n_results;
    int                 n_pixels;

    function new();
      width_reg  = WidthW'(MaxWidth);
      height_reg = HeightW'(2);
      held_px    = '0;
      col_pos    = 0;
      row_pos    = 0;
      n_errors   = 0;
      n_results  = 0;
      n_pixels   = 0;
      foreach (pair_line[i]) pair_line[i] = '0;
    endfunction

    function void apply_reg(cfg_reg_e idx, logic [CfgW-1:0] value);
      case (idx)
        RegImageWidth: begin
          width_reg = value[WidthW-1:0];
        end
        RegImageHeight: begin
          height_reg = value[HeightW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned active_width();
      return (width_reg > MaxWidth) ? MaxWidth : width_reg;
    endfunction

    function logic [ChanW-1:0] quarter(logic [SumW-1:0] a, logic [SumW-1:0] b);
      return ChanW'(({1'b0, a} + {1'b0, b}) >> 2);
    endfunction

    function void absorb_pixel(pixel_t px);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      pair_t       now_pair;
      pair_t       old_pair;
      result_t     res;
      w = active_width();
      h = height_reg;
      n_pixels++;
      if (col_pos < w) begin
        if (col_pos % 2 == 0) begin
          held_px = px;
        end else begin
          now_pair.red   = {1'b0, held_px.red} + px.red;
          now_pair.green = {1'b0, held_px.green} + px.green;
          now_pair.blue  = {1'b0, held_px.blue} + px.blue;
          slot = (col_pos / 2) % LineDepth;
          if (row_pos % 2 == 0) begin
            pair_line[slot] = now_pair;
          end else if (row_pos < h) begin
            old_pair = pair_line[slot];
            res.red_avg    = quarter(old_pair.red, now_pair.red);
            res.green_avg  = quarter(old_pair.green, now_pair.green);
            res.blue_avg   = quarter(old_pair.blue, now_pair.blue);
            res.out_col    = OutColW'(col_pos / 2);
            res.out_row    = OutRowW'(row_pos / 2);
            res.frame_last = (col_pos / 2 + 1 == w / 2) && (row_pos / 2 + 1 == h / 2);
            block_avgs_q.push_back(res);
          end
        end
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
      col_pos = col_pos & 32'h7FF;
      row_pos = row_pos & 32'hFFFF;
    endfunction

    task report(string msg);
      if (n_errors < 40) $display("ERROR @%0t: %s", $time, msg);
      n_errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want, result_t ref_res);
      if (got !== want) begin
        report($sformatf("%s got %0h want %0h (block col %0d row %0d)",
                         name, got, want, ref_res.out_col, ref_res.out_row));
      end
    endtask

    task check_block_avg(result_t got);
      result_t want;
      if (block_avgs_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = block_avgs_q.pop_front();
      n_results++;
      compare_field("red_avg", got.red_avg, want.red_avg, want);
      compare_field("green_avg", got.green_avg, want.green_avg, want);
      compare_field("blue_avg", got.blue_avg, want.blue_avg, want);
      compare_field("out_col", got.out_col, want.out_col, want);
      compare_field("out_row", got.out_row, want.out_row, want);
      compare_field("frame_last", got.frame_last, want.frame_last, want);
    endtask
  endclass

endpackage

// File: verif/tb_top.sv
// Testbench top for the RGB 2x2 box downscaler: stimulus, handshakes and run control.
`timescale 1ns / 1ps
module tb_top;
  import rbds_pkg::*;
  import box_avg_check_pkg::*;

  localparam int CycleLimit   = 8_000_000;
  localparam int SettleCycles = 8;
  localparam int RandomPixels = 1400;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  pixel_t              in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  result_t             out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]     cfg_data  = '0;

  bit                  calm          = 1'b0;
  int                  hold_left     = 0;
  int                  stall_roll    = 0;
  int                  n_cfg_writes  = 0;
  int                  n_mid_changes = 0;
  box_avg_scoreboard   sb = new();

  rgb_box_downscale_2x2_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // output back-pressure: short and long stalls, free stretches
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall <= 1'b0;
        hold_left = $urandom_range(0, 7);
      end else if (stall_roll < 92) begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(3, 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_block_avg(out_data);
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = 24'($urandom);
    if ($urandom_range(0, 5) == 0) px = {24{px.red[0]}};
    return px;
  endfunction

  function automatic int pick_width();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(0, 1);
    if (roll < 75) return $urandom_range(2, 16);
    if (roll < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 300);
  endfunction

  function automatic int pick_height(int w);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(0, 1);
    if (w > 64 || roll < 85) return $urandom_range(2, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic push_pixel(input pixel_t px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_pixel(px);
  endtask

  task automatic stream(input int n);
    repeat (n) push_pixel(rand_pixel());
  endtask

  task automatic finish_frame();
    do begin
      push_pixel(rand_pixel());
    end while (sb.col_pos != 0 || sb.row_pos != 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.block_avgs_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.apply_reg(idx, value);
    n_cfg_writes++;
    @(posedge clk);
  endtask

  // upper bits beyond the 12-bit width field are junk now and then
  task automatic write_width(input int w);
    if ($urandom_range(0, 3) == 0) cfg_write(RegImageWidth, {4'($urandom), 12'(w)});
    else cfg_write(RegImageWidth, CfgW'(w));
  endtask

  task automatic set_size(input int w, input int h);
    settle();
    cfg_write(RegImageWidth, CfgW'(w));
    cfg_write(RegImageHeight, CfgW'(h));
  endtask

  task automatic directed_part();
    pixel_t corner [8];
    corner = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFF00FF,
               24'hFFFFFF, 24'hFFFFFF, 24'h00FF00, 24'hFEFF01};
    set_size(4, 2);
    foreach (corner[i]) push_pixel(corner[i]);
    // odd width and height: last column and row dropped
    set_size(3, 3);
    stream(9);
    // sizes too small to give any output
    set_size(1, 2);
    stream(2);
    set_size(2, 1);
    stream(2);
    set_size(0, 0);
    stream(2);
  endtask

  // config changes mid-frame are kept to ones that never read a stale line entry
  task automatic random_part();
    int start_count;
    int w_cur;
    int w_new;
    int h_new;
    start_count = sb.n_pixels;
    while (sb.n_pixels - start_count < RandomPixels) begin
      settle();
      calm = ($urandom_range(0, 4) == 0);
      w_cur = sb.active_width();
      if (sb.col_pos == 0 && sb.row_pos == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          w_new = pick_width();
          write_width(w_new);
          cfg_write(RegImageHeight, CfgW'(pick_height(w_new)));
        end
      end else if ($urandom_range(0, 2) == 0) begin
        if (sb.col_pos != 0) begin
          w_new = $urandom_range(0, 1) ? w_cur : $urandom_range(0, sb.col_pos);
        end else if (sb.row_pos % 2 == 1) begin
          w_new = $urandom_range(0, w_cur);
        end else begin
          w_new = pick_width();
        end
        h_new = $urandom_range(0, 1) ? int'(sb.height_reg) : pick_height(w_new);
        write_width(w_new);
        cfg_write(RegImageHeight, CfgW'(h_new));
        n_mid_changes++;
      end
      if ($urandom_range(0, 2) == 0) stream($urandom_range(1, 40));
      else finish_frame();
    end
  endtask

  task automatic extremes_part();
    settle();
    if (sb.col_pos != 0 || sb.row_pos != 0) finish_frame();
    calm = 1'b0;
    // width 1 under the tallest height: every pixel ends a row
    set_size(1, 16'hFFFF);
    stream(41);
    // row counter already past the new height wraps at the next row end
    set_size(2, 2);
    finish_frame();
    // width register above the line store size is clamped; row cut short
    settle();
    cfg_write(RegImageWidth, 16'hFFFF);
    stream(40);
    settle();
    cfg_write(RegImageWidth, CfgW'(2));
    finish_frame();
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    random_part();
    extremes_part();
    $display("tb_top: %0d pixels in, %0d block averages checked, %0d register writes",
             sb.n_pixels, sb.n_results, n_cfg_writes);
    $display("tb_top: %0d mid-frame size changes; widths 0..2048, heights 0..65535",
             n_mid_changes);
    if (sb.n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rbds_pkg.sv
rtl/core/rbds_ram.sv
rtl/core/rgb_box_downscale_2x2_unit.sv
rtl/core/rbds_check.sv
verif/box_avg_check_pkg.sv
verif/tb_top.sv
